>>> rtl/core/arqrx_pkg.sv
package arqrx_pkg;

  localparam int WINDOW_MAX_DEF = 8;

  localparam int MAX_RES = 3;
  localparam int RES_CW  = $clog2(MAX_RES + 1);
  localparam int ODEPTH  = 4;
  localparam int OCW     = $clog2(ODEPTH + 1);

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;

  localparam logic [1:0] KIND_RNR    = 2'd0;
  localparam logic [1:0] KIND_RR     = 2'd1;
  localparam logic [1:0] KIND_QREPLY = 2'd2;

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_ACK_EVERY   = 1'b1;

  localparam logic [3:0] WINDOW_SIZE_RST = 4'd7;
  localparam logic [7:0] ACK_EVERY_RST   = 8'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] ack_num;
    logic [3:0] window;
    logic       last;
  } res_t;

endpackage

>>> rtl/core/arqrx_cell.sv
module arqrx_cell #(
  parameter int W = 3
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] right_data,
  output logic [W-1:0] data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= right_data;
    end
  end

endmodule

>>> rtl/core/arq_receiver_flow_control.sv
// Receive side of a mod-8 sliding-window link with RR/RNR flow control.
// Input channel (in_valid/in_stall, fields op, seq, lost) carries data
// packets (op 0), window queries (op 1) and ignored messages (op 2, 3).
// Output channel (out_valid/out_stall, fields kind, ack_num, window, last)
// carries RNR, RR and query replies; each request gives zero to three
// replies, the final one marked by last.
// Configuration: cfg_we writes cfg_data into window_size (index 0) or
// ack_every (index 1); write only while the block is idle.
// The replies of a request are registered into the reply queue as it is taken.
// Throughput: one request per cycle while each gives at most one reply and
// out_stall is low; a four-entry reply queue drains one reply per cycle while
// out_stall is low, and requests are taken while it holds at most one reply,
// so a request with several replies holds back later requests until they drain.
// Received sequence numbers sit in a row of shift cells, head in cell 0.
// Reset: clears counts, expected number and flags, empties the reply queue,
// and restores window_size to 7 and ack_every to 1.
// A stalled receiver holds the queue; in_stall is high while the queue holds
// two or more replies.
module arq_receiver_flow_control #(
  parameter int WINDOW_MAX = arqrx_pkg::WINDOW_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [2:0] seq,
  input  logic       lost,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [2:0] ack_num,
  output logic [3:0] window,
  output logic       last
);
  import arqrx_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [3:0]    window_size;
  logic [7:0]    ack_every;
  logic [CW-1:0] count, count_next;
  logic [2:0]    expected, expected_next;
  logic [7:0]    accept_count, accept_mid, accept_next;
  logic          full_flag, full_mid, full_next;
  logic          rnr_pending, rnr_mid, rnr_next;

  logic          acc, is_data, is_query;
  logic [CW-1:0] cap, cnt_push;
  logic          full_hit, full_set, push, pop;
  logic [2:0]    head, rr_num;
  logic          ev_rnr, ev_rrf, ev_rrp;

  logic [2:0]    seq_data [WINDOW_MAX];

  res_t          ev_res [4];
  logic [3:0]    ev_on;
  res_t          res [MAX_RES];
  logic [RES_CW-1:0] nres;

  logic [OCW-1:0] ocount, obase;
  logic           opop;
  res_t           oq_data [ODEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
      ack_every   <= ACK_EVERY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE: window_size <= cfg_data[3:0];
        REG_ACK_EVERY:   ack_every   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign acc      = in_valid && !in_stall;
  assign is_data  = acc && (op == OP_DATA) && !lost;
  assign is_query = acc && (op == OP_QUERY);

  always_comb begin
    if (int'(window_size) >= WINDOW_MAX) cap = CW'(WINDOW_MAX);
    else cap = CW'(window_size);
    full_hit = count >= cap;
    push     = is_data && !full_hit;
    cnt_push = count + CW'(push);
    head     = (count == '0) ? seq : seq_data[0];
    pop      = push && (head == expected);
    count_next    = cnt_push - CW'(pop);
    expected_next = expected + 3'(pop);
    full_set = is_data && (full_hit || (cnt_push == cap));
    full_mid = full_flag || full_set;
    rnr_mid  = rnr_pending || full_set;
    ev_rnr   = full_set && !rnr_pending;
    ev_rrf   = push && (count_next < cap) && full_mid;
    full_next = ev_rrf ? 1'b0 : full_mid;
    rnr_next  = ev_rrf ? 1'b0 : rnr_mid;
    accept_mid = (pop && (accept_count != 8'hff)) ? accept_count + 8'd1 : accept_count;
    ev_rrp = push && (accept_mid >= ack_every);
    accept_next = ev_rrp ? 8'd0 : accept_mid;
    rr_num = expected_next - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      expected     <= '0;
      accept_count <= '0;
      full_flag    <= 1'b0;
      rnr_pending  <= 1'b0;
    end else begin
      count        <= count_next;
      expected     <= expected_next;
      accept_count <= accept_next;
      full_flag    <= full_next;
      rnr_pending  <= rnr_next;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_seq
    logic          ld;
    logic [2:0]    right;
    if (i == WINDOW_MAX - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = seq_data[i+1];
    end
    assign ld = pop ? (push && (count == CW'(i + 1)))
                    : (push && (count == CW'(i)));
    arqrx_cell #(.W(3)) u_cell (
      .clk        (clk),
      .shift      (pop),
      .load       (ld),
      .load_data  (seq),
      .right_data (right),
      .data       (seq_data[i])
    );
  end

  always_comb begin
    ev_on[0] = is_query;
    ev_res[0] = '{kind: KIND_QREPLY, ack_num: 3'd0, window: window_size, last: 1'b0};
    ev_on[1] = ev_rnr;
    ev_res[1] = '{kind: KIND_RNR, ack_num: 3'd0, window: 4'd0, last: 1'b0};
    ev_on[2] = ev_rrf;
    ev_res[2] = '{kind: KIND_RR, ack_num: rr_num, window: 4'd0, last: 1'b0};
    ev_on[3] = ev_rrp;
    ev_res[3] = '{kind: KIND_RR, ack_num: rr_num, window: 4'd0, last: 1'b0};
    nres = '0;
    for (int r = 0; r < MAX_RES; r++) res[r] = '0;
    for (int e = 0; e < 4; e++) begin
      if (ev_on[e] && (int'(nres) < MAX_RES)) begin
        res[nres[1:0]] = ev_res[e];
        nres = nres + RES_CW'(1);
      end
    end
    if (nres != '0) res[2'(nres - RES_CW'(1))].last = 1'b1;
  end

  assign out_valid = ocount != '0;
  assign opop      = out_valid && !out_stall;
  assign obase     = ocount - OCW'(opop);
  assign in_stall  = ocount > OCW'(ODEPTH - MAX_RES);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= '0;
    end else begin
      ocount <= obase + OCW'(nres);
    end
  end

  for (genvar i = 0; i < ODEPTH; i++) begin : g_oq
    logic [OCW-1:0] off;
    logic           ld;
    res_t           right;
    if (i == ODEPTH - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = oq_data[i+1];
    end
    assign off = OCW'(i) - obase;
    assign ld  = (OCW'(i) >= obase) && (off < OCW'(nres));
    arqrx_cell #(.W($bits(res_t))) u_cell (
      .clk        (clk),
      .shift      (opop),
      .load       (ld),
      .load_data  (res[off[1:0]]),
      .right_data (right),
      .data       (oq_data[i])
    );
  end

  assign kind    = oq_data[0].kind;
  assign ack_num = oq_data[0].ack_num;
  assign window  = oq_data[0].window;
  assign last    = oq_data[0].last;

endmodule
